[rtl/afskdd_pkg.sv]
// Shared types, constants and a helper function for the AFSK delay discriminator demodulator.
package afskdd_pkg;

   // Delay line covers half a bit period
   localparam int DELAY_TAPS = 4;
   localparam int PTR_W      = (DELAY_TAPS > 1) ? $clog2(DELAY_TAPS) : 1;

   localparam int SAMPLE_W = 8;
   localparam int Y_W      = 16;
   localparam int HIST_W   = 8;
   localparam int PHASE_W  = 8;
   localparam int STEP_W   = 7;
   localparam int NUDGE_W  = 5;
   localparam int LIMIT_W  = 8;
   localparam int THRESH_W = 7;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(8);
   localparam logic [NUDGE_W-1:0]  NUDGE_RST  = NUDGE_W'(1);
   localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(64);
   localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(32);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP      = 2'd0,
      CSR_PHASE_NUDGE     = 2'd1,
      CSR_PHASE_LIMIT     = 2'd2,
      CSR_PHASE_THRESHOLD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [STEP_W-1:0]   step;
      logic [NUDGE_W-1:0]  nudge;
      logic [LIMIT_W-1:0]  limit;
      logic [THRESH_W-1:0] threshold;
   } phase_cfg_type;

   typedef struct packed {
      logic              bit_ready;
      logic              bit_value;
      logic [HIST_W-1:0] decided;
   } bit_result_type;

   // Sign patterns that vote for a one
   localparam logic [2:0] VOTE_ALL   = 3'h7;
   localparam logic [2:0] VOTE_HI2   = 3'h6;
   localparam logic [2:0] VOTE_SPLIT = 3'h5;
   localparam logic [2:0] VOTE_LO2   = 3'h3;

   function automatic logic majority3(input logic [2:0] b);
      return (b == VOTE_ALL) || (b == VOTE_HI2) || (b == VOTE_SPLIT) || (b == VOTE_LO2);
   endfunction

endpackage

[rtl/afskdd_slicer.sv]
// Bit slicer: sign history, bit-phase tracking and majority bit decision.
module afskdd_slicer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic signed [afskdd_pkg::Y_W-1:0] y,
   input  afskdd_pkg::phase_cfg_type         cfg,
   output afskdd_pkg::bit_result_type        res
);
   import afskdd_pkg::*;

   logic [HIST_W-1:0]  sign_hist_ff, sign_hist_in;
   logic [HIST_W-1:0]  decided_ff, decided_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   logic               sign_new;
   logic               edge_hit;
   logic [PHASE_W-1:0] ph_adj;
   logic [PHASE_W-1:0] ph_sum;
   logic               hit;
   logic               vote;

   always_comb begin
      sign_new     = (y > 0);
      sign_hist_in = {sign_hist_ff[HIST_W-2:0], sign_new};
      edge_hit     = sign_hist_in[0] ^ sign_hist_in[1];

      // nudge toward the threshold on a sign change
      ph_adj = phase_ff;
      if (edge_hit) begin
         if (phase_ff < PHASE_W'(cfg.threshold)) begin
            ph_adj = phase_ff + PHASE_W'(cfg.nudge);
         end else begin
            ph_adj = phase_ff - PHASE_W'(cfg.nudge);
         end
      end
      ph_sum = ph_adj + PHASE_W'(cfg.step);

      hit      = (ph_sum >= PHASE_W'(cfg.limit));
      phase_in = hit ? (ph_sum - PHASE_W'(cfg.limit)) : ph_sum;
      vote     = hit & majority3(sign_hist_in[2:0]);
      decided_in = hit ? {decided_ff[HIST_W-2:0], vote} : decided_ff;

      res.bit_ready = hit;
      res.bit_value = vote;
      res.decided   = decided_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_hist_ff <= '0;
         decided_ff   <= '0;
         phase_ff     <= '0;
      end else if (en) begin
         sign_hist_ff <= sign_hist_in;
         decided_ff   <= decided_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

[rtl/afsk_delay_discriminator_demod_core.sv]
// Top level of the AFSK delay-line discriminator demodulator.
//
// Usage:
//   Input channel (req_): one signed 8-bit audio sample per request.
//   Result channel (rsp_): one result per request, in order: bit_ready,
//   bit_value, decided_history and the 16-bit low-pass filter output.
//   Config port (csr_): write-only; csr_index selects phase_step (0),
//   phase_nudge (1), phase_limit (2) or phase_threshold (3). Write only
//   while no request is in flight.
// Pipeline and throughput:
//   Two register stages. Stage one reads the delay tap and multiplies;
//   stage two runs the filter sum and the phase compare chain into the
//   result register. A taken request is held in the stage-one register,
//   then in the result register, where rsp_valid shows it.
//   One request per cycle is sustained while rsp_ready stays high.
// Reset:
//   Synchronous, active high. Clears the delay line, filter state, sign and
//   bit history, bit phase and both valid flags; config returns to defaults.
// Stall:
//   When rsp_ready is low a full result register holds; if stage one is
//   empty, one more request is still taken into it, after which req_ready drops.
module afsk_delay_discriminator_demod_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [afskdd_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_bit_ready,
   output logic                                     rsp_bit_value,
   output logic [afskdd_pkg::HIST_W-1:0]            rsp_decided_history,
   output logic signed [afskdd_pkg::Y_W-1:0]        rsp_discriminator_out,
   input  logic                                     csr_wr_en,
   input  logic [afskdd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [afskdd_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import afskdd_pkg::*;

   // configuration registers
   phase_cfg_type cfg_ff;

   // delay line
   logic [SAMPLE_W-1:0] tap_ff [DELAY_TAPS];
   logic [PTR_W-1:0]    ptr_ff, ptr_in;

   // stage one
   logic                  s1_vld_ff, s1_vld_in;
   logic signed [Y_W-1:0] s1_prod_ff;

   // filter state
   logic signed [Y_W-1:0] prev_prod_ff;
   logic signed [Y_W-1:0] y_prev_ff;

   // result register
   logic                  rsp_vld_ff, rsp_vld_in;
   bit_result_type        rsp_bits_ff;
   logic signed [Y_W-1:0] rsp_y_ff;

   logic                  req_take;
   logic                  adv;
   logic                  s2_fire;
   logic signed [Y_W-1:0] old_ext;
   logic signed [Y_W-1:0] cur_ext;
   logic signed [Y_W-1:0] mult_full;
   logic signed [Y_W-1:0] prod;
   logic signed [Y_W-1:0] y_sum;
   bit_result_type        slice_res;

   // ---------------- handshake ----------------
   // advance the result register whenever it is empty or being drained
   assign adv       = !rsp_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || adv;
   assign req_take  = req_valid && req_ready;
   assign s2_fire   = adv && s1_vld_ff;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_take) begin
         s1_vld_in = 1'b1;
      end else if (adv) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = adv ? s1_vld_ff : rsp_vld_ff;
   end

   // ---------------- config writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step      <= STEP_RST;
         cfg_ff.nudge     <= NUDGE_RST;
         cfg_ff.limit     <= LIMIT_RST;
         cfg_ff.threshold <= THRESH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PHASE_STEP:      cfg_ff.step      <= csr_wdata[STEP_W-1:0];
            CSR_PHASE_NUDGE:     cfg_ff.nudge     <= csr_wdata[NUDGE_W-1:0];
            CSR_PHASE_LIMIT:     cfg_ff.limit     <= csr_wdata[LIMIT_W-1:0];
            CSR_PHASE_THRESHOLD: cfg_ff.threshold <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage one: delay tap and product ----------------
   always_comb begin
      old_ext   = Y_W'($signed(tap_ff[ptr_ff]));
      cur_ext   = Y_W'(req_sample);
      mult_full = old_ext * cur_ext;   // fits 16 bits for any 8-bit pair
      prod      = mult_full >>> 2;
      ptr_in    = (ptr_ff == PTR_W'(DELAY_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int i = 0; i < DELAY_TAPS; i++) begin
            tap_ff[i] <= '0;
         end
      end else if (req_take) begin
         // read oldest tap above, then overwrite it with the new sample
         tap_ff[ptr_ff] <= req_sample;
         ptr_ff         <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_prod_ff <= prod;
      end
   end

   // ---------------- stage two: low-pass filter ----------------
   // y = x0 + x1 + y/2 + y/8 + y/32, wraps at 16 bits
   assign y_sum = prev_prod_ff + s1_prod_ff
                + (y_prev_ff >>> 1) + (y_prev_ff >>> 3) + (y_prev_ff >>> 5);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_prod_ff <= '0;
         y_prev_ff    <= '0;
      end else if (s2_fire) begin
         prev_prod_ff <= s1_prod_ff;
         y_prev_ff    <= y_sum;
      end
   end

   afskdd_slicer u_slicer (
      .clock (clock),
      .reset (reset),
      .en    (s2_fire),
      .y     (y_sum),
      .cfg   (cfg_ff),
      .res   (slice_res)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_bits_ff <= slice_res;
         rsp_y_ff    <= y_sum;
      end
   end

   assign rsp_valid             = rsp_vld_ff;
   assign rsp_bit_ready         = rsp_bits_ff.bit_ready;
   assign rsp_bit_value         = rsp_bits_ff.bit_value;
   assign rsp_decided_history   = rsp_bits_ff.decided;
   assign rsp_discriminator_out = rsp_y_ff;

endmodule

[rtl/afskdd_checker.sv]
// Port-level checker for the AFSK demodulator core, with its bind.
module afskdd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic                                   rsp_bit_ready,
   input logic                                   rsp_bit_value,
   input logic [afskdd_pkg::HIST_W-1:0]          rsp_decided_history,
   input logic signed [afskdd_pkg::Y_W-1:0]      rsp_discriminator_out
);
   import afskdd_pkg::*;

   // no result may show without a request behind it right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty result register never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // a decided one must be set only with a decision
   a_value_needs_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bit_value |-> rsp_bit_ready)
      else $error("bit value without bit ready");

   // a fresh decision is the newest history bit
   a_history_newest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bit_ready |-> (rsp_decided_history[0] == rsp_bit_value))
      else $error("decided history does not hold the new bit");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_discriminator_out)
                                 && $stable(rsp_decided_history))
      else $error("stalled result changed");

endmodule

bind afsk_delay_discriminator_demod_core afskdd_checker u_afskdd_checker (.*);

[bench/afsk_demod_checker.sv]
// Demodulator scoreboard: watches request, result and register traffic, predicts and compares.
`timescale 1ns / 100ps

module afsk_demod_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [afskdd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic                                   rsp_bit_ready,
   input  logic                                   rsp_bit_value,
   input  logic [afskdd_pkg::HIST_W-1:0]          rsp_decided_history,
   input  logic signed [afskdd_pkg::Y_W-1:0]      rsp_discriminator_out,
   input  logic                                   csr_wr_en,
   input  logic [afskdd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [afskdd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                     mismatch_count,
   output int                                     outstanding
);
   import afskdd_pkg::*;

   localparam int PRINT_CAP = 200;

   typedef struct packed {
      logic              bit_ready;
      logic              bit_value;
      logic [HIST_W-1:0] history;
      logic [Y_W-1:0]    filter_out;
   } demod_result_type;

   demod_result_type expected_bits_q[$];

   // Shadow of the datapath state
   logic signed [SAMPLE_W-1:0] tap_line [DELAY_TAPS];
   logic [PTR_W-1:0]           tap_ptr;
   int                         last_product;
   int                         last_filter;
   logic [HIST_W-1:0]          sign_hist;
   logic [HIST_W-1:0]          bit_hist;
   logic [PHASE_W-1:0]         phase_acc;

   // Shadow of the phase registers
   logic [STEP_W-1:0]   cfg_step;
   logic [NUDGE_W-1:0]  cfg_nudge;
   logic [LIMIT_W-1:0]  cfg_limit;
   logic [THRESH_W-1:0] cfg_threshold;

   int results_seen;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      results_seen   = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: result %0d: %s", $time, results_seen, msg);
      mismatch_count++;
   endtask

   // Advance the shadow demodulator by one sample and return what the block must answer
   function automatic demod_result_type predict_demod(input logic signed [SAMPLE_W-1:0] s);
      demod_result_type      r;
      int                    product;
      int                    y;
      logic signed [Y_W-1:0] y16;
      logic [PHASE_W-1:0]    ph;
      logic [2:0]            votes;
      product = (int'(tap_line[tap_ptr]) * int'(s)) >>> 2;
      y = last_product + product
          + (last_filter >>> 1) + (last_filter >>> 3) + (last_filter >>> 5);
      y16 = y[Y_W-1:0];
      last_product = product;
      last_filter = int'(y16);
      tap_line[tap_ptr] = s;
      tap_ptr = (tap_ptr == PTR_W'(DELAY_TAPS - 1)) ? '0 : tap_ptr + 1'b1;
      sign_hist = {sign_hist[HIST_W-2:0], (y16 > 0)};
      ph = phase_acc;
      if (sign_hist[0] != sign_hist[1])
         ph = (ph < cfg_threshold) ? ph + cfg_nudge : ph - cfg_nudge;
      ph = ph + cfg_step;
      r.bit_ready = (ph >= cfg_limit);
      r.bit_value = 1'b0;
      if (r.bit_ready) begin
         votes = sign_hist[2:0];
         ph = ph - cfg_limit;
         r.bit_value = (votes[0] & votes[1]) | (votes[0] & votes[2]) | (votes[1] & votes[2]);
         bit_hist = {bit_hist[HIST_W-2:0], r.bit_value};
      end
      phase_acc = ph;
      r.history = bit_hist;
      r.filter_out = y16;
      return r;
   endfunction

   always @(posedge clock) begin
      demod_result_type want;
      if (reset) begin
         foreach (tap_line[i])
            tap_line[i] = '0;
         tap_ptr       = '0;
         last_product  = 0;
         last_filter   = 0;
         sign_hist     = '0;
         bit_hist      = '0;
         phase_acc     = '0;
         cfg_step      = STEP_RST;
         cfg_nudge     = NUDGE_RST;
         cfg_limit     = LIMIT_RST;
         cfg_threshold = THRESH_RST;
         expected_bits_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PHASE_STEP:      cfg_step      = csr_wdata[STEP_W-1:0];
               CSR_PHASE_NUDGE:     cfg_nudge     = csr_wdata[NUDGE_W-1:0];
               CSR_PHASE_LIMIT:     cfg_limit     = csr_wdata[LIMIT_W-1:0];
               CSR_PHASE_THRESHOLD: cfg_threshold = csr_wdata[THRESH_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bits_q.size() == 0) begin
               report_mismatch("result arrived with no request pending");
            end else begin
               want = expected_bits_q.pop_front();
               if (rsp_bit_ready !== want.bit_ready)
                  report_mismatch($sformatf("bit_ready got %b want %b",
                                            rsp_bit_ready, want.bit_ready));
               if (rsp_bit_value !== want.bit_value)
                  report_mismatch($sformatf("bit_value got %b want %b",
                                            rsp_bit_value, want.bit_value));
               if (rsp_decided_history !== want.history)
                  report_mismatch($sformatf("decided_history got %h want %h",
                                            rsp_decided_history, want.history));
               if (rsp_discriminator_out !== want.filter_out)
                  report_mismatch($sformatf("discriminator_out got %h want %h",
                                            rsp_discriminator_out, want.filter_out));
            end
            results_seen++;
         end
         if (req_valid && req_ready)
            expected_bits_q.push_back(predict_demod(req_sample));
      end
      outstanding = expected_bits_q.size();
   end

endmodule

[bench/afsk_delay_discriminator_demod_core_tb.sv]
// Testbench top for the AFSK delay discriminator demodulator: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module afsk_delay_discriminator_demod_core_tb;
   import afskdd_pkg::*;

   localparam int RANDOM_PHASES   = 11;
   localparam int ITEMS_PER_PHASE = 123;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 4;

   // Receiver back-pressure styles, each held for a stretch of cycles
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_bit_ready;
   logic                       rsp_bit_value;
   logic [HIST_W-1:0]          rsp_decided_history;
   logic signed [Y_W-1:0]      rsp_discriminator_out;
   logic                       csr_wr_en;
   csr_index_type              csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;

   // Opening sequence: full-scale runs build up the filter, then alternating
   // extremes and small values toggle the sign history and hit every product corner
   logic signed [SAMPLE_W-1:0] sweep_samples [24] = '{
      -128, -128, -128, -128, -128, -128, 127, 127,
       127,  127, -128,  127, -128,  127,   0,   0,
        -1,    1,   -1,    1,   64,  -64, 100, -100
   };

   afsk_delay_discriminator_demod_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_bit_ready         (rsp_bit_ready),
      .rsp_bit_value         (rsp_bit_value),
      .rsp_decided_history   (rsp_decided_history),
      .rsp_discriminator_out (rsp_discriminator_out),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   afsk_demod_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_bit_ready         (rsp_bit_ready),
      .rsp_bit_value         (rsp_bit_value),
      .rsp_decided_history   (rsp_decided_history),
      .rsp_discriminator_out (rsp_discriminator_out),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatch_count        (mismatch_count),
      .outstanding           (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: give up if the run stalls or drags on far beyond its normal length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: pick a stall style for a random stretch, then drive rsp_ready from it
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 96);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN:  rsp_ready <= 1'b1;
         RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:  rsp_ready <= ((rx_left % 5) > 1);
      endcase
   end

   // Present one request at a falling edge and hold it until it is taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every predicted result has been returned
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (outstanding != 0);
   endtask

   // Write all four phase registers back to back; the block is idle here
   task automatic write_phase_cfg(input logic [CSR_DATA_W-1:0] step,
                                  input logic [CSR_DATA_W-1:0] nudge,
                                  input logic [CSR_DATA_W-1:0] limit,
                                  input logic [CSR_DATA_W-1:0] thresh);
      logic [CSR_DATA_W-1:0] vals [4];
      csr_index_type         regs [4];
      vals = '{step, nudge, limit, thresh};
      regs = '{CSR_PHASE_STEP, CSR_PHASE_NUDGE, CSR_PHASE_LIMIT, CSR_PHASE_THRESHOLD};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] s;
      logic [CSR_DATA_W-1:0]      c_step, c_nudge, c_limit, c_thresh;
      int n, k, burst, gap, v;
      int seg_left, tone_period, tone_amp, tone_pos;
      bit seg_noise, steady;

      req_valid  = 1'b0;
      req_sample = '0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_PHASE_STEP;
      csr_wdata  = '0;
      reset      = 1'b1;
      seg_left   = 0;
      seg_noise  = 1'b0;
      tone_period = 2;
      tone_amp   = 1;
      tone_pos   = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Reset values again, with junk in the bits above the step, nudge and threshold widths
      write_phase_cfg(8'h88, 8'hE1, 8'd64, 8'hA0);
      foreach (sweep_samples[i])
         send_sample(sweep_samples[i]);

      for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
         wait_all_results();

         case (phase)
            // smallest legal step, no nudge, tightest limit and threshold
            1: write_phase_cfg(8'd1, 8'd0, 8'd2, 8'd1);
            // largest legal values
            2: write_phase_cfg(8'd64, 8'd16, 8'd128, 8'd127);
            // zero step and threshold, widest nudge, limit zero decides on every sample
            3: write_phase_cfg(8'h80, 8'hFF, 8'd0, 8'h80);
            // full-width values: phase sum wraps past 255
            4: write_phase_cfg(8'h7F, 8'h1F, 8'hFF, 8'h7F);
            // limit of one
            5: write_phase_cfg(8'd3, 8'd5, 8'd1, 8'd64);
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  c_step   = CSR_DATA_W'($urandom_range(0, 255));
                  c_nudge  = CSR_DATA_W'($urandom_range(0, 255));
                  c_limit  = CSR_DATA_W'($urandom_range(0, 255));
                  c_thresh = CSR_DATA_W'($urandom_range(0, 255));
               end else begin
                  c_step   = CSR_DATA_W'($urandom_range(1, 64));
                  c_nudge  = CSR_DATA_W'($urandom_range(0, 16));
                  c_limit  = CSR_DATA_W'($urandom_range(2, 128));
                  c_thresh = CSR_DATA_W'($urandom_range(1, 127));
               end
               write_phase_cfg(c_step, c_nudge, c_limit, c_thresh);
            end
         endcase

         // Every third phase the sender never idles
         steady = (phase % 3 == 0);
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && n < ITEMS_PER_PHASE; k++) begin
               // Content comes in segments: mostly square tones of random pitch
               // and level, now and then a stretch of full-range noise
               if (seg_left == 0) begin
                  seg_left    = $urandom_range(6, 40);
                  seg_noise   = ($urandom_range(0, 4) == 0);
                  tone_period = $urandom_range(2, 12);
                  tone_amp    = $urandom_range(1, 127);
                  tone_pos    = 0;
               end
               seg_left--;
               if (seg_noise) begin
                  s = SAMPLE_W'($urandom_range(0, 255));
               end else begin
                  v = (tone_pos < tone_period / 2) ? tone_amp : -tone_amp;
                  v = v + int'($urandom_range(0, 8)) - 4;
                  if (v > 127)
                     v = 127;
                  else if (v < -128)
                     v = -128;
                  s = v[SAMPLE_W-1:0];
                  tone_pos = (tone_pos + 1) % tone_period;
               end
               send_sample(s);
               n++;
            end
            if (!steady) begin
               if ($urandom_range(0, 15) == 0) begin
                  wait_all_results();
               end else begin
                  gap = $urandom_range(0, 6);
                  if (gap != 0) begin
                     req_valid <= 1'b0;
                     repeat (gap) @(negedge clock);
                  end
               end
            end
         end
      end

      // Drain, then keep watching to catch any stray result before the verdict
      wait_all_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
rtl/afskdd_pkg.sv
rtl/afskdd_slicer.sv
rtl/afsk_delay_discriminator_demod_core.sv
rtl/afskdd_checker.sv
bench/afsk_demod_checker.sv
bench/afsk_delay_discriminator_demod_core_tb.sv
